>>> rtl/core/glsu_pkg.sv
// Shared types, field layouts and step codes for the grid Laplacian stencil unit.
package glsu_pkg;

    // Field widths of one input transfer and one result transfer.
    localparam int COLUMN_W   = 6;
    localparam int ROW_W      = 6;
    localparam int LAYER_W    = 2;
    localparam int SAMPLE_W   = 32;
    localparam int LAP_W      = 35;

    // Packing of the input tdata, first field in the lowest bits.
    localparam int COLUMN_LSB = 0;
    localparam int ROW_LSB    = COLUMN_LSB + COLUMN_W;
    localparam int LAYER_LSB  = ROW_LSB + ROW_W;
    localparam int SAMPLE_LSB = LAYER_LSB + LAYER_W;
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 1;

    // Result tdata is the Laplacian padded with zeros to whole bytes.
    localparam int M_TDATA_W  = 40;
    localparam int M_PAD_W    = M_TDATA_W - LAP_W;

    // Operation codes carried on s_tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Order in which the five stencil words are fetched.
    localparam logic [2:0] STEP_CENTRE = 3'd0;
    localparam logic [2:0] STEP_LEFT   = 3'd1;
    localparam logic [2:0] STEP_UP     = 3'd2;
    localparam logic [2:0] STEP_RIGHT  = 3'd3;
    localparam logic [2:0] STEP_DOWN   = 3'd4;
    localparam logic [2:0] STEP_END    = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_DONE
    } fsm_state_t;

endpackage

>>> rtl/core/glsu_ram.sv
// Generic single-port RAM with registered read data.
module glsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/core/grid_laplacian_stencil_unit.sv
// Top level of the five-point Laplacian stencil unit over a stack of lattices.
//
//   Channel   Direction  Handshake          Payload
//   s_*       in         s_tvalid/s_tready  s_tdata: column, row, layer, sample; s_tuser: op
//   m_*       out        m_tvalid/m_tready  m_tdata: laplacian (35 bits, zero padded)
//   cfg_*     in         cfg_we             cfg_wdata: periodic_wrap
//
// A write transfer stores its sample in the same cycle and the block is ready again at once.
// A read transfer keeps the block busy from acceptance until its result is loaded:
// the single-port lattice memory delivers one stencil word per cycle, and the five words
// pass through the registered read into the sum before the result load.
// A read outside the lattice skips the memory and goes straight to the result load.
// Reset (aresetn low at a clock edge) clears control and the wrap register; the lattice
// memory is not cleared. If the result register is still occupied, the sequencer waits
// in its final state until m_tready frees it.
module grid_laplacian_stencil_unit #(
    parameter int GRID_COLUMNS = 64,
    parameter int GRID_ROWS    = 64,
    parameter int LAYERS       = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: periodic_wrap.
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // From bit 0: column[6], row[6], layer[2], sample[32], zero pad[2].
    input  logic [glsu_pkg::S_TDATA_W-1:0] s_tdata,
    // Bit 0: op.
    input  logic [glsu_pkg::S_TUSER_W-1:0] s_tuser,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // From bit 0: laplacian[35], zero pad[5].
    output logic [glsu_pkg::M_TDATA_W-1:0] m_tdata
);
    import glsu_pkg::*;

    // The memory address is the concatenation {layer, row, column}, so each
    // coordinate gets its own bit field and no multiplication is needed.
    localparam int XW    = $clog2(GRID_COLUMNS);
    localparam int YW    = $clog2(GRID_ROWS);
    localparam int ZW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int AW    = XW + YW + ZW;
    localparam int DEPTH = 2 ** AW;

    localparam logic [XW-1:0] X_LAST = XW'(GRID_COLUMNS - 1);
    localparam logic [YW-1:0] Y_LAST = YW'(GRID_ROWS - 1);

    // Input field extraction.
    logic [COLUMN_W-1:0] in_column;
    logic [ROW_W-1:0]    in_row;
    logic [LAYER_W-1:0]  in_layer;
    logic [SAMPLE_W-1:0] in_sample;
    logic                in_op;
    logic                in_inside;
    logic                in_xfer;

    assign in_column = s_tdata[COLUMN_LSB +: COLUMN_W];
    assign in_row    = s_tdata[ROW_LSB +: ROW_W];
    assign in_layer  = s_tdata[LAYER_LSB +: LAYER_W];
    assign in_sample = s_tdata[SAMPLE_LSB +: SAMPLE_W];
    assign in_op     = s_tuser[0];
    assign in_inside = (int'(in_column) < GRID_COLUMNS) && (int'(in_row) < GRID_ROWS) &&
                       (int'(in_layer) < LAYERS);

    // Sequencer and datapath registers.
    fsm_state_t       state_reg, state_next;
    logic             wrap_reg;
    logic [XW-1:0]    x_reg, x_next;
    logic [YW-1:0]    y_reg, y_next;
    logic [ZW-1:0]    z_reg, z_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [2:0]       step_reg, step_next;
    logic             data_vld_reg, data_vld_next;
    logic [LAP_W-1:0] acc_reg, acc_next;
    logic [LAP_W-1:0] lap_reg, lap_next;
    logic             m_valid_reg, m_valid_next;

    // Memory port.
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [SAMPLE_W-1:0] ram_rdata;

    // Neighbour coordinates; at an edge they point at the opposite edge, and the
    // word is dropped later when wrapping is off.
    logic [XW-1:0] x_left, x_right;
    logic [YW-1:0] y_up, y_down;
    logic [AW-1:0] step_addr;

    // Shared adder operands.
    logic             term_use;
    logic             term_sub;
    logic [LAP_W-1:0] term_word;
    logic [LAP_W-1:0] term_addend;

    assign x_left  = (x_reg == '0)     ? X_LAST : x_reg - XW'(1);
    assign x_right = (x_reg == X_LAST) ? '0     : x_reg + XW'(1);
    assign y_up    = (y_reg == '0)     ? Y_LAST : y_reg - YW'(1);
    assign y_down  = (y_reg == Y_LAST) ? '0     : y_reg + YW'(1);

    always_comb begin
        case (cnt_reg)
            STEP_LEFT:  step_addr = {z_reg, y_reg, x_left};
            STEP_UP:    step_addr = {z_reg, y_up, x_reg};
            STEP_RIGHT: step_addr = {z_reg, y_reg, x_right};
            STEP_DOWN:  step_addr = {z_reg, y_down, x_reg};
            default:    step_addr = {z_reg, y_reg, x_reg};
        endcase
    end

    // Whether the word that arrives now belongs in the sum, and with which sign.
    always_comb begin
        term_sub = 1'b0;
        case (step_reg)
            STEP_CENTRE: begin
                term_use = 1'b1;
                term_sub = 1'b1;
            end
            STEP_LEFT:  term_use = (x_reg != '0) || wrap_reg;
            STEP_UP:    term_use = (y_reg != '0) || wrap_reg;
            STEP_RIGHT: term_use = (x_reg != X_LAST) || wrap_reg;
            STEP_DOWN:  term_use = (y_reg != Y_LAST) || wrap_reg;
            default:    term_use = 1'b0;
        endcase
    end

    // The centre enters as four times its value, subtracted; neighbours are added.
    assign term_word   = term_sub ? {ram_rdata[SAMPLE_W-1], ram_rdata, 2'b00}
                                  : {{(LAP_W - SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata};
    assign term_addend = term_use ? term_word : '0;

    always_comb begin
        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        cnt_next      = cnt_reg;
        step_next     = step_reg;
        data_vld_next = 1'b0;
        acc_next      = acc_reg;
        lap_next      = lap_reg;
        m_valid_next  = m_valid_reg;
        ram_we        = 1'b0;
        ram_addr      = step_addr;
        s_tready      = (state_reg == ST_IDLE);
        in_xfer       = s_tvalid && s_tready;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // One shared add/subtract unit folds each returning word into the sum.
        if (data_vld_reg) begin
            acc_next = acc_reg + (term_sub ? ~term_addend : term_addend) + LAP_W'(term_sub);
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (in_op == OP_WRITE) begin
                        ram_we   = in_inside;
                        ram_addr = {ZW'(in_layer), YW'(in_row), XW'(in_column)};
                    end else begin
                        x_next     = XW'(in_column);
                        y_next     = YW'(in_row);
                        z_next     = ZW'(in_layer);
                        cnt_next   = STEP_CENTRE;
                        acc_next   = '0;
                        state_next = in_inside ? ST_GATHER : ST_DONE;
                    end
                end
            end
            ST_GATHER: begin
                if (cnt_reg != STEP_END) begin
                    data_vld_next = 1'b1;
                    step_next     = cnt_reg;
                    cnt_next      = cnt_reg + 3'd1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    lap_next     = acc_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= STEP_CENTRE;
            data_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            data_vld_reg <= data_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_reg <= 1'b0;
        end else if (cfg_we) begin
            wrap_reg <= cfg_wdata;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        step_reg <= step_next;
        acc_reg  <= acc_next;
        lap_reg  <= lap_next;
    end

    glsu_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_lattice_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_sample),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, lap_reg};

endmodule

>>> rtl/core/glsu_checker.sv
// Port-level checker for the stencil unit and its bind to the top level.
module glsu_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [glsu_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [glsu_pkg::M_TDATA_W-1:0] m_tdata
);
    import glsu_pkg::*;

    // After reset the block is empty and ready.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    // A read keeps the block busy while it gathers the stencil.
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == OP_READ) |=> !s_tready)
        else $error("ready after read transfer");

    // A write finishes in the cycle it is taken.
    a_write_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == OP_WRITE) |=> s_tready)
        else $error("not ready after write transfer");

    // The pad bits above the Laplacian stay zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:LAP_W] == '0))
        else $error("result pad bits not zero");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind grid_laplacian_stencil_unit glsu_checker u_glsu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/grid_laplacian_stencil_unit_tb.sv
// Self-checking testbench for the five-point Laplacian stencil unit.
module grid_laplacian_stencil_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import glsu_pkg::*;

    // Lattice geometry. These values are also passed to the instance so that the
    // predictor and the block agree on the shape of every layer.
    localparam int GRID_COLUMNS = 64;
    localparam int GRID_ROWS    = 64;
    localparam int LAYERS       = 4;
    localparam int SITES        = GRID_COLUMNS * GRID_ROWS * LAYERS;

    // The random part stops once this many input transfers have gone in.
    localparam int ITEM_TARGET  = 1650;
    localparam int PHASES       = 6;
    // The drain wait outlasts a read still inside the block.
    localparam int DRAIN_CYCLES = 24;
    // The slowest correct run is near 1700 transfers, each one held up by the
    // longest sender gap, the block's read time and the longest receiver stall.
    // The limit leaves ample room over such a run.
    localparam longint CYCLE_LIMIT = 1_000_000;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ONE = 32'h0001_0000;

    // The scoreboard holds a private copy of every lattice and of the wrap register.
    // It works out the Laplacian of each accepted read and keeps it in a queue until
    // the matching result transfer comes out of the block.
    class lattice_scoreboard;
        bit [SAMPLE_W-1:0] lattice [SITES];
        bit                filled  [SITES];
        bit                wrap;
        logic [LAP_W-1:0]  laplacians_due [$];
        int                failures;

        function int site_index(int c, int r, int l);
            return c + GRID_COLUMNS * (r + GRID_ROWS * l);
        endfunction

        function longint value_at(int c, int r, int l);
            return longint'($signed(lattice[site_index(c, r, l)]));
        endfunction

        // A site is safe to read once its centre and all four neighbours, taken
        // with wrap, hold written samples. Wrapped neighbours are demanded even
        // with wrap off, so no read ever touches an unwritten word.
        function bit readable(int c, int r, int l);
            return filled[site_index(c, r, l)]
                && filled[site_index((c + GRID_COLUMNS - 1) % GRID_COLUMNS, r, l)]
                && filled[site_index((c + 1) % GRID_COLUMNS, r, l)]
                && filled[site_index(c, (r + GRID_ROWS - 1) % GRID_ROWS, l)]
                && filled[site_index(c, (r + 1) % GRID_ROWS, l)];
        endfunction

        function int pending_count();
            return laplacians_due.size();
        endfunction

        // Called once for every accepted input transfer, in acceptance order.
        function void note_transfer(logic op, int c, int r, int l,
                                    logic [SAMPLE_W-1:0] sample);
            longint acc;
            if (op == OP_WRITE) begin
                lattice[site_index(c, r, l)] = sample;
                filled[site_index(c, r, l)]  = 1'b1;
                return;
            end
            acc = -4 * value_at(c, r, l);
            // A neighbour beyond an edge comes from the opposite edge with wrap on,
            // and counts as zero with wrap off.
            if (c > 0) begin
                acc += value_at(c - 1, r, l);
            end else if (wrap) begin
                acc += value_at(GRID_COLUMNS - 1, r, l);
            end
            if (r > 0) begin
                acc += value_at(c, r - 1, l);
            end else if (wrap) begin
                acc += value_at(c, GRID_ROWS - 1, l);
            end
            if (c < GRID_COLUMNS - 1) begin
                acc += value_at(c + 1, r, l);
            end else if (wrap) begin
                acc += value_at(0, r, l);
            end
            if (r < GRID_ROWS - 1) begin
                acc += value_at(c, r + 1, l);
            end else if (wrap) begin
                acc += value_at(c, 0, l);
            end
            laplacians_due.push_back(acc[LAP_W-1:0]);
        endfunction

        // Called once for every accepted result transfer.
        function void check_result(logic [M_TDATA_W-1:0] tdata);
            logic [LAP_W-1:0] want;
            if (laplacians_due.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, $signed(tdata[LAP_W-1:0]));
                return;
            end
            want = laplacians_due.pop_front();
            if (tdata[LAP_W-1:0] !== want) begin
                failures++;
                $display("%0t: laplacian mismatch, expected %0d, actual %0d",
                         $time, $signed(want), $signed(tdata[LAP_W-1:0]));
            end
            if (tdata[M_TDATA_W-1:LAP_W] !== '0) begin
                failures++;
                $display("%0t: padding mismatch, expected %0h, actual %0h",
                         $time, {M_PAD_W{1'b0}}, tdata[M_TDATA_W-1:LAP_W]);
            end
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_wdata = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    lattice_scoreboard board = new();
    int     items_sent  = 0;
    int     stall_left  = 0;
    longint cycles      = 0;
    // While set, neither side inserts gaps, so back-to-back transfers get exercised.
    bit     quiet       = 1'b0;
    // Sites whose whole stencil has been written, kept as flat lattice indexes.
    int     safe_sites [$];

    grid_laplacian_stencil_unit #(
        .GRID_COLUMNS(GRID_COLUMNS),
        .GRID_ROWS   (GRID_ROWS),
        .LAYERS      (LAYERS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Coordinates lean toward the edges, where the wrap logic lives.
    function automatic int pick_coord(int extent);
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            return 0;
        end
        if (r < 40) begin
            return extent - 1;
        end
        if (r < 50) begin
            return $urandom_range(0, 1) ? 1 : extent - 2;
        end
        return $urandom_range(0, extent - 1);
    endfunction

    // Samples lean toward the extremes of Q16.16 and toward small values.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] noise;
        int r;
        noise = $urandom;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            return SAMPLE_MIN;
        end
        if (r < 24) begin
            return SAMPLE_MAX;
        end
        if (r < 32) begin
            return '0;
        end
        if (r < 44) begin
            return {{14{noise[17]}}, noise[17:0]};
        end
        return noise;
    endfunction

    // The receiver stalls at random: it drops m_tready for a run of cycles and
    // then raises it again. Quiet stretches keep it high.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 99) < 25) begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Every result transfer is checked against the oldest expected Laplacian.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Presents one item, holds it until the transfer happens and hands it to the
    // scoreboard. The task always returns at the edge of the transfer, with
    // s_tvalid still high; the next call either lowers it or replaces the data
    // in that same step, so the accepted item is never offered twice.
    task automatic send_item(logic op, int c, int r, int l, logic [SAMPLE_W-1:0] sample);
        int gap;
        logic [S_TDATA_W-1:0] word;
        gap  = pick_gap();
        word = '0;
        word[COLUMN_LSB +: COLUMN_W] = COLUMN_W'(c);
        word[ROW_LSB    +: ROW_W]    = ROW_W'(r);
        word[LAYER_LSB  +: LAYER_W]  = LAYER_W'(l);
        word[SAMPLE_LSB +: SAMPLE_W] = sample;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= word;
        s_tuser[0] <= op;
        do @(posedge aclk); while (!s_tready);
        board.note_transfer(op, c, r, l, sample);
        items_sent++;
    endtask

    // A read carries random bits in its sample field, which the block must ignore.
    task automatic read_site(int idx);
        send_item(OP_READ, idx % GRID_COLUMNS, (idx / GRID_COLUMNS) % GRID_ROWS,
                  idx / (GRID_COLUMNS * GRID_ROWS), $urandom);
    endtask

    // Writes the centre and the four wrapped neighbours of a site. With vary set,
    // each neighbour gets its own random sample; otherwise they all get rim.
    task automatic write_cross(int c, int r, int l, logic [SAMPLE_W-1:0] centre,
                               logic [SAMPLE_W-1:0] rim, bit vary);
        send_item(OP_WRITE, c, r, l, centre);
        send_item(OP_WRITE, (c + GRID_COLUMNS - 1) % GRID_COLUMNS, r, l,
                  vary ? pick_sample() : rim);
        send_item(OP_WRITE, c, (r + GRID_ROWS - 1) % GRID_ROWS, l,
                  vary ? pick_sample() : rim);
        send_item(OP_WRITE, (c + 1) % GRID_COLUMNS, r, l, vary ? pick_sample() : rim);
        send_item(OP_WRITE, c, (r + 1) % GRID_ROWS, l, vary ? pick_sample() : rim);
        safe_sites.push_back(board.site_index(c, r, l));
    endtask

    // The wrap register is only written with the block idle: the input is parked,
    // every expected result has come back, and the drain time has passed.
    task automatic set_wrap(bit wrap_on);
        s_tvalid <= 1'b0;
        while (board.pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= wrap_on;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        board.wrap  = wrap_on;
    endtask

    // One step of the random stimulus. Half the steps are well-formed: a full stencil
    // is written and then read. The rest re-read known sites, scatter stray writes
    // over the lattice, or write a lone centre and read it only where that is safe.
    task automatic random_step();
        int r;
        int c;
        int row;
        int l;
        r   = $urandom_range(0, 99);
        c   = pick_coord(GRID_COLUMNS);
        row = pick_coord(GRID_ROWS);
        l   = $urandom_range(0, LAYERS - 1);
        quiet = ($urandom_range(0, 9) == 0);
        if (r < 50) begin
            write_cross(c, row, l, pick_sample(), '0, 1'b1);
            read_site(board.site_index(c, row, l));
            if ($urandom_range(0, 1)) begin
                read_site(safe_sites[$urandom_range(0, safe_sites.size() - 1)]);
            end
        end else if (r < 75) begin
            read_site(safe_sites[$urandom_range(0, safe_sites.size() - 1)]);
        end else if (r < 88) begin
            send_item(OP_WRITE, $urandom_range(0, GRID_COLUMNS - 1),
                      $urandom_range(0, GRID_ROWS - 1), l, pick_sample());
        end else begin
            send_item(OP_WRITE, c, row, l, pick_sample());
            if (board.readable(c, row, l)) begin
                read_site(board.site_index(c, row, l));
            end else begin
                read_site(safe_sites[$urandom_range(0, safe_sites.size() - 1)]);
            end
        end
    endtask

    initial begin
        int phase_end;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. Opposite corners on the outer layers get the extreme
        // samples, so the Laplacian reaches both ends of its range; an interior
        // site checks the plain case. Each is read with wrap off and then on.
        set_wrap(1'b0);
        write_cross(0, 0, 0, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        write_cross(GRID_COLUMNS - 1, GRID_ROWS - 1, LAYERS - 1, SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        write_cross(20, 40, 2, SAMPLE_ONE, '0, 1'b1);
        read_site(board.site_index(0, 0, 0));
        read_site(board.site_index(GRID_COLUMNS - 1, GRID_ROWS - 1, LAYERS - 1));
        read_site(board.site_index(20, 40, 2));
        set_wrap(1'b1);
        read_site(board.site_index(0, 0, 0));
        read_site(board.site_index(GRID_COLUMNS - 1, GRID_ROWS - 1, LAYERS - 1));
        read_site(board.site_index(20, 40, 2));

        // Random part, split into phases that alternate the wrap setting.
        for (int phase = 0; phase < PHASES; phase++) begin
            set_wrap(phase % 2 == 1);
            phase_end = items_sent + ITEM_TARGET / PHASES;
            while (items_sent < phase_end) begin
                random_step();
            end
        end

        // Park the input, let the last results drain, then give the verdict.
        quiet = 1'b0;
        s_tvalid <= 1'b0;
        while (board.pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
